// ===== rtl/glm_rss_pkg.sv =====
// ----------------------------------------------------------------------------
// glm_rss_pkg
// Shared sizes, opcodes, command and state types for the residual SS block.
// ----------------------------------------------------------------------------
package glm_rss_pkg;

  localparam int MAX_TERMS    = 16;
  localparam int MAX_SAMPLES  = 256;
  localparam int TERM_W       = $clog2(MAX_TERMS);
  localparam int ROW_W        = $clog2(MAX_SAMPLES);
  localparam int DESIGN_DEPTH = MAX_SAMPLES * MAX_TERMS;
  localparam int TERMS_W      = 5;
  localparam int VAL_W        = 32;
  localparam int ACC_W        = 64;

  localparam logic [1:0] OP_DESIGN = 2'd0;
  localparam logic [1:0] OP_COEF   = 2'd1;
  localparam logic [1:0] OP_SAMPLE = 2'd2;

  typedef enum logic [1:0] {
    CMD_DESIGN,
    CMD_COEF,
    CMD_SAMPLE
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [ROW_W-1:0]   row;
    logic [TERM_W-1:0]  col;
    logic [VAL_W-1:0]   value;
    logic               last;
  } cmd_t;

  // handshake between command queue and back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_head_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_RESID,
    S_MAG,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_ACC,
    S_OUT
  } back_state_t;

endpackage

// ===== rtl/glm_rss_ram.sv =====
// ----------------------------------------------------------------------------
// glm_rss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module glm_rss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/glm_rss_front.sv =====
// ----------------------------------------------------------------------------
// glm_rss_front
// Input side: takes requests, decodes the opcode, drops unused codes.
// ----------------------------------------------------------------------------
module glm_rss_front import glm_rss_pkg::*; (
  input  logic              push,
  output logic              full,
  input  logic [1:0]        opcode,
  input  logic [ROW_W-1:0]  row_index,
  input  logic [TERM_W-1:0] col_index,
  input  logic [VAL_W-1:0]  value,
  input  logic              last,
  input  logic              q_full,
  output logic              cmd_push,
  output cmd_t              cmd
);

  logic keep;

  assign full = q_full;

  always_comb begin
    keep      = 1'b1;
    cmd.kind  = CMD_SAMPLE;
    cmd.row   = row_index;
    cmd.col   = col_index;
    cmd.value = value;
    // last only means something on a sample
    cmd.last  = last && (opcode == OP_SAMPLE);
    unique case (opcode)
      OP_DESIGN: cmd.kind = CMD_DESIGN;
      OP_COEF:   cmd.kind = CMD_COEF;
      OP_SAMPLE: cmd.kind = CMD_SAMPLE;
      default:   keep     = 1'b0;
    endcase
  end

  assign cmd_push = push && !q_full && keep;

endmodule

// ===== rtl/glm_rss_cmd_q.sv =====
// ----------------------------------------------------------------------------
// glm_rss_cmd_q
// Two-entry command queue between front and back end.
// ----------------------------------------------------------------------------
module glm_rss_cmd_q import glm_rss_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_push,
  input  cmd_t      cmd_in,
  output logic      q_full,
  input  logic      cmd_pop,
  output cmd_head_t head
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign q_full     = (count == 2'd2);
  assign head.valid = (count != 2'd0);
  assign head.cmd   = slots[rd_ptr];
  assign do_push    = cmd_push && !q_full;
  assign do_pop     = cmd_pop && head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= cmd_in;
    end
  end

endmodule

// ===== rtl/glm_rss_back.sv =====
// ----------------------------------------------------------------------------
// glm_rss_back
// Execution side: table loads, term-by-term prediction, square and sum.
// ----------------------------------------------------------------------------
module glm_rss_back import glm_rss_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [TERMS_W-1:0] terms_in_use,
  input  cmd_head_t          head,
  output logic               cmd_pop,
  output logic               empty,
  input  logic               pop,
  output logic [ACC_W-1:0]   residual_ss,
  output logic               saturated
);

  typedef struct packed {
    logic [ACC_W-1:0] val;
    logic             ovf;
  } sat_t;

  function automatic sat_t sat_add_s(input logic [ACC_W-1:0] a, input logic [ACC_W-1:0] b);
    sat_t             r;
    logic [ACC_W-1:0] s;
    s     = a + b;
    r.ovf = (a[ACC_W-1] == b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1]);
    r.val = r.ovf ? {a[ACC_W-1], {(ACC_W-1){!a[ACC_W-1]}}} : s;
    return r;
  endfunction

  function automatic sat_t sat_sub_s(input logic [ACC_W-1:0] a, input logic [ACC_W-1:0] b);
    sat_t             r;
    logic [ACC_W-1:0] s;
    s     = a - b;
    r.ovf = (a[ACC_W-1] != b[ACC_W-1]) && (s[ACC_W-1] != a[ACC_W-1]);
    r.val = r.ovf ? {a[ACC_W-1], {(ACC_W-1){!a[ACC_W-1]}}} : s;
    return r;
  endfunction

  function automatic sat_t sat_add_u(input logic [ACC_W-1:0] a, input logic [ACC_W-1:0] b);
    sat_t           r;
    logic [ACC_W:0] s;
    s     = {1'b0, a} + {1'b0, b};
    r.ovf = s[ACC_W];
    r.val = r.ovf ? {ACC_W{1'b1}} : s[ACC_W-1:0];
    return r;
  endfunction

  back_state_t state, state_next;

  // control
  logic               issue;
  logic               ram_we;
  logic               v1, v2;
  logic [TERM_W:0]    k;
  logic [TERM_W:0]    n_terms;
  logic               res_load;
  logic               res_valid;

  // datapath
  logic [ROW_W-1:0]   row_q;
  logic               last_q;
  logic [ACC_W-1:0]   sample_q;
  logic [VAL_W-1:0]   coefs [MAX_TERMS];
  logic [VAL_W-1:0]   ram_q;
  logic signed [VAL_W-1:0] coef_q;
  logic signed [ACC_W-1:0] prod;
  logic [ACC_W-1:0]   pred;
  logic [ACC_W-1:0]   diff;
  logic [ACC_W-1:0]   mag;
  logic [31:0]        hh;
  logic [47:0]        hl;
  logic [63:0]        ll;
  logic [ACC_W-1:0]   sq;
  logic [ACC_W-1:0]   square_sum;
  logic               overflow_seen;

  sat_t pred_add, diff_sub, sq_step1, sq_step2, sum_add;

  assign n_terms = (terms_in_use > TERMS_W'(MAX_TERMS)) ? (TERM_W+1)'(MAX_TERMS)
                                                         : (TERM_W+1)'(terms_in_use);

  assign pred_add = sat_add_s(pred, prod);
  assign diff_sub = sat_sub_s(sample_q, pred);
  assign sq_step1 = sat_add_u({hh, 32'd0}, {15'd0, hl, 1'b0});
  assign sq_step2 = sat_add_u(sq, {32'd0, ll[63:32]});
  assign sum_add  = sat_add_u(square_sum, sq);

  glm_rss_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DESIGN_DEPTH)
  ) u_design (
    .clk   (clk),
    .we    (ram_we),
    .waddr ({head.cmd.row, head.cmd.col}),
    .wdata (head.cmd.value),
    .raddr ({row_q, k[TERM_W-1:0]}),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_pop    = 1'b0;
    ram_we     = 1'b0;
    issue      = 1'b0;
    res_load   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (head.valid) begin
          cmd_pop = 1'b1;
          unique case (head.cmd.kind)
            CMD_DESIGN: ram_we = 1'b1;
            CMD_COEF:   ram_we = 1'b0;
            CMD_SAMPLE: state_next = (n_terms == '0) ? S_RESID : S_MAC;
            default:    ram_we = 1'b0;
          endcase
        end
      end
      S_MAC: begin
        issue = 1'b1;
        if (k == n_terms - 1'b1) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!v1 && !v2) begin
          state_next = S_RESID;
        end
      end
      S_RESID: state_next = S_MAG;
      S_MAG:   state_next = S_MUL1;
      S_MUL1:  state_next = (mag[ACC_W-1:48] != '0) ? S_ACC : S_MUL2;
      S_MUL2:  state_next = S_MUL3;
      S_MUL3:  state_next = S_ACC;
      S_ACC:   state_next = last_q ? S_OUT : S_IDLE;
      S_OUT: begin
        if (!res_valid || pop) begin
          res_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // pipeline valids and result register control
  always_ff @(posedge clk) begin
    if (rst) begin
      v1            <= 1'b0;
      v2            <= 1'b0;
      res_valid     <= 1'b0;
      square_sum    <= '0;
      overflow_seen <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_RESID: overflow_seen <= overflow_seen | diff_sub.ovf;
        S_MUL1:  overflow_seen <= overflow_seen | (mag[ACC_W-1:48] != '0);
        S_MUL2:  overflow_seen <= overflow_seen | sq_step1.ovf;
        S_MUL3:  overflow_seen <= overflow_seen | sq_step2.ovf;
        S_ACC: begin
          overflow_seen <= overflow_seen | sum_add.ovf;
          square_sum    <= sum_add.val;
        end
        S_OUT: begin
          if (res_load) begin
            overflow_seen <= 1'b0;
            square_sum    <= '0;
          end
        end
        default: overflow_seen <= overflow_seen | (v2 && pred_add.ovf);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (v2) begin
      pred <= pred_add.val;
    end
    coef_q <= coefs[k[TERM_W-1:0]];
    prod   <= coef_q * $signed(ram_q);
    if (res_load) begin
      residual_ss <= square_sum;
      saturated   <= overflow_seen;
    end
    if (issue) begin
      k <= k + 1'b1;
    end
    unique case (state)
      S_IDLE: begin
        k    <= '0;
        pred <= '0;
        if (head.valid && head.cmd.kind == CMD_COEF) begin
          coefs[head.cmd.col] <= head.cmd.value;
        end
        row_q    <= head.cmd.row;
        last_q   <= head.cmd.last;
        sample_q <= {{16{head.cmd.value[VAL_W-1]}}, head.cmd.value, 16'd0};
      end
      S_RESID: diff <= diff_sub.val;
      S_MAG:   mag  <= diff[ACC_W-1] ? (ACC_W'(0) - diff) : diff;
      S_MUL1: begin
        hh <= mag[47:32] * mag[47:32];
        hl <= mag[47:32] * mag[31:0];
        sq <= {ACC_W{1'b1}};
      end
      S_MUL2: begin
        ll <= mag[31:0] * mag[31:0];
        sq <= sq_step1.val;
      end
      S_MUL3:  sq <= sq_step2.val;
      default: sq <= sq;
    endcase
  end

  assign empty = !res_valid;

endmodule

// ===== rtl/glm_residual_sum_of_squares_top.sv =====
// ----------------------------------------------------------------------------
// glm_residual_sum_of_squares_top
// Residual sum of squares of a linear model, one voxel at a time.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake            Payload
// input     in         push / full          opcode, row_index, col_index, value, last
// result    out        empty / pop          residual_ss, saturated
// config    in         terms_in_use_we      terms_in_use_wdata
//
// Steps: a design or coefficient load is written from the idle state. A data
// sample runs the term loop (n = terms in use, capped at 16), then residual,
// magnitude, square and sum; no terms in use skips the loop, a saturating
// square skips the later square steps, and the last sample then loads the
// result register, waiting while an earlier result is not yet popped. The
// loop uses one shared multiply-accumulate fed by the design RAM read port.
// Reset clears the queue, the pipeline, the sum and the flag; the design and
// coefficient tables hold no defined value until loaded.
// A two-entry queue lets the input keep taking requests while the back end
// works or waits on a full result register.
// ----------------------------------------------------------------------------
module glm_residual_sum_of_squares_top import glm_rss_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  // input requests
  input  logic               push,
  output logic               full,
  input  logic [1:0]         opcode,
  input  logic [ROW_W-1:0]   row_index,
  input  logic [TERM_W-1:0]  col_index,
  input  logic [VAL_W-1:0]   value,
  input  logic               last,
  // results
  output logic               empty,
  input  logic               pop,
  output logic [ACC_W-1:0]   residual_ss,
  output logic               saturated,
  // configuration
  input  logic               terms_in_use_we,
  input  logic [TERMS_W-1:0] terms_in_use_wdata
);

  logic               q_full;
  logic               cmd_push;
  cmd_t               cmd;
  cmd_head_t          head;
  logic               cmd_pop;
  logic [TERMS_W-1:0] terms_in_use;

  // term count register, reset to a single term
  always_ff @(posedge clk) begin
    if (rst) begin
      terms_in_use <= TERMS_W'(1);
    end else if (terms_in_use_we) begin
      terms_in_use <= terms_in_use_wdata;
    end
  end

  // front: decode and drop unused opcodes
  glm_rss_front u_front (
    .push      (push),
    .full      (full),
    .opcode    (opcode),
    .row_index (row_index),
    .col_index (col_index),
    .value     (value),
    .last      (last),
    .q_full    (q_full),
    .cmd_push  (cmd_push),
    .cmd       (cmd)
  );

  // decoupling queue
  glm_rss_cmd_q u_cmd_q (
    .clk      (clk),
    .rst      (rst),
    .cmd_push (cmd_push),
    .cmd_in   (cmd),
    .q_full   (q_full),
    .cmd_pop  (cmd_pop),
    .head     (head)
  );

  // back: loads, prediction, residual square, sum and result register
  glm_rss_back u_back (
    .clk          (clk),
    .rst          (rst),
    .terms_in_use (terms_in_use),
    .head         (head),
    .cmd_pop      (cmd_pop),
    .empty        (empty),
    .pop          (pop),
    .residual_ss  (residual_ss),
    .saturated    (saturated)
  );

endmodule

// ===== rtl/glm_rss_checker.sv =====
// ----------------------------------------------------------------------------
// glm_rss_checker
// Port-level checks on the residual SS block, bound to the top level.
// ----------------------------------------------------------------------------
module glm_rss_port_checks import glm_rss_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               push,
  input logic               full,
  input logic               empty,
  input logic               pop,
  input logic [ACC_W-1:0]   residual_ss,
  input logic               saturated
);

  // no result and free queue straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("result or queue not clear after reset");

  // a waiting result holds until taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(residual_ss) && $stable(saturated))
    else $error("waiting result changed before pop");

  // the queue only fills on a request
  a_full_on_push: assert property (@(posedge clk) disable iff (rst)
    !full && !push |=> !full)
    else $error("queue filled without a request");

endmodule

bind glm_residual_sum_of_squares_top glm_rss_port_checks u_chk (.*);

// ===== tb/sv/glm_rss_checker.sv =====
// ----------------------------------------------------------------------------
// glm_rss_checker
// Watches the request, result and configuration ports of the residual SS
// block, predicts each voxel result and compares it field by field.
// ----------------------------------------------------------------------------
module glm_rss_checker import glm_rss_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic               full,
  input  logic [1:0]         opcode,
  input  logic [ROW_W-1:0]   row_index,
  input  logic [TERM_W-1:0]  col_index,
  input  logic [VAL_W-1:0]   value,
  input  logic               last,
  input  logic               empty,
  input  logic               pop,
  input  logic [ACC_W-1:0]   residual_ss,
  input  logic               saturated,
  input  logic               terms_in_use_we,
  input  logic [TERMS_W-1:0] terms_in_use_wdata,
  output int                 fail_count,
  output int                 expected_left
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ACC_W-1:0] rss;
    logic             sat;
  } voxel_result_t;

  logic [VAL_W-1:0]   design_mem [DESIGN_DEPTH];
  logic [VAL_W-1:0]   coef_mem   [MAX_TERMS];
  logic [ACC_W-1:0]   rss_acc;
  logic               voxel_sat;
  logic [TERMS_W-1:0] terms_q;
  voxel_result_t      rss_q [$];
  int                 mismatches;

  // signed 64-bit add or subtract, clamped; flags the voxel on clamp
  function automatic logic [63:0] clamp_s64(input logic [63:0] a, input logic [63:0] b,
                                            input logic subtract);
    logic [65:0] s;
    s = subtract ? {{2{a[63]}}, a} - {{2{b[63]}}, b} : {{2{a[63]}}, a} + {{2{b[63]}}, b};
    if (s[65:63] == 3'b000 || s[65:63] == 3'b111) return s[63:0];
    voxel_sat = 1'b1;
    return s[65] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
  endfunction

  function automatic logic [63:0] add_u64_sat(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (!s[64]) return s[63:0];
    voxel_sat = 1'b1;
    return '1;
  endfunction

  // floor(d^2 / 2^32), clamped to 2^64-1
  function automatic logic [63:0] square_q32(input logic [63:0] d);
    logic [63:0]  mag;
    logic [127:0] sq;
    mag = d[63] ? (~d + 64'd1) : d;
    sq  = {64'd0, mag} * {64'd0, mag};
    if (sq[127:96] != 32'd0) begin
      voxel_sat = 1'b1;
      return '1;
    end
    return sq[95:32];
  endfunction

  function automatic void absorb_request(input logic [1:0] op, input logic [ROW_W-1:0] row,
                                         input logic [TERM_W-1:0] col,
                                         input logic [VAL_W-1:0] val, input logic lst);
    int          n;
    logic [63:0] pred;
    logic [63:0] prod;
    logic [63:0] x;
    logic [63:0] c;
    logic [63:0] resid;
    case (op)
      OP_DESIGN: design_mem[int'(row) * MAX_TERMS + int'(col)] = val;
      OP_COEF:   coef_mem[col] = val;
      OP_SAMPLE: begin
        n    = (int'(terms_q) > MAX_TERMS) ? MAX_TERMS : int'(terms_q);
        pred = 64'd0;
        for (int k = 0; k < n; k++) begin
          x    = {{32{design_mem[int'(row) * MAX_TERMS + k][31]}},
                  design_mem[int'(row) * MAX_TERMS + k]};
          c    = {{32{coef_mem[k][31]}}, coef_mem[k]};
          prod = c * x;
          pred = clamp_s64(pred, prod, 1'b0);
        end
        resid   = clamp_s64({{16{val[31]}}, val, 16'd0}, pred, 1'b1);
        rss_acc = add_u64_sat(rss_acc, square_q32(resid));
        if (lst) begin
          rss_q.push_back('{rss: rss_acc, sat: voxel_sat});
          rss_acc   = '0;
          voxel_sat = 1'b0;
        end
      end
      default: ;  // spare opcode: no effect
    endcase
  endfunction

  always @(posedge clk) begin
    voxel_result_t want;
    if (rst) begin
      rss_acc    = '0;
      voxel_sat  = 1'b0;
      terms_q    = TERMS_W'(1);
      mismatches = 0;
      rss_q.delete();
    end else begin
      if (terms_in_use_we) terms_q = terms_in_use_wdata;
      if (pop && !empty) begin
        if (rss_q.size() == 0) begin
          $error("unexpected result: residual_ss %h saturated %b", residual_ss, saturated);
          mismatches++;
        end else begin
          want = rss_q.pop_front();
          if (residual_ss !== want.rss) begin
            $error("residual_ss: expected %h, actual %h", want.rss, residual_ss);
            mismatches++;
          end
          if (saturated !== want.sat) begin
            $error("saturated: expected %b, actual %b", want.sat, saturated);
            mismatches++;
          end
        end
      end
      if (push && !full) absorb_request(opcode, row_index, col_index, value, last);
    end
    fail_count    <= mismatches;
    expected_left <= rss_q.size();
  end

endmodule

// ===== tb/sv/tb_glm_residual_sum_of_squares_top.sv =====
// ----------------------------------------------------------------------------
// tb_glm_residual_sum_of_squares_top
// Drives the residual SS block with directed and random voxel requests under
// random back-pressure; a checker beside the block predicts every result.
// ----------------------------------------------------------------------------
module tb_glm_residual_sum_of_squares_top import glm_rss_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  // spare opcode, must be ignored by the block
  localparam logic [1:0] OP_NONE      = 2'd3;
  localparam int         NUM_PHASES   = 10;
  localparam int         PER_PHASE    = 175;   // loads and samples per setting
  localparam int         SETTLE       = 100;   // wait for the back end to drain, in cycles
  localparam int         STALL_LIMIT  = 3000;  // cycles with no traffic at all
  localparam int         CALM_PHASE   = 3;
  // term counts per phase: above the cap, one, the cap, five, full 5-bit, zero, then others
  localparam logic [NUM_PHASES*TERMS_W-1:0] PHASE_TERMS =
    {5'd12, 5'd2, 5'd9, 5'd3, 5'd0, 5'd31, 5'd5, 5'd16, 5'd1, 5'd17};

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic [1:0]         opcode = OP_DESIGN;
  logic [ROW_W-1:0]   row_index = '0;
  logic [TERM_W-1:0]  col_index = '0;
  logic [VAL_W-1:0]   value = '0;
  logic               last = 1'b0;
  logic               empty;
  logic               pop = 1'b0;
  logic [ACC_W-1:0]   residual_ss;
  logic               saturated;
  logic               terms_in_use_we = 1'b0;
  logic [TERMS_W-1:0] terms_in_use_wdata = '0;

  int fail_count;
  int expected_left;

  // stimulus bookkeeping: which table entries hold a value, so that a sample
  // never reads an entry that was never loaded
  bit [MAX_TERMS-1:0] design_ok [MAX_SAMPLES];
  bit [MAX_TERMS-1:0] coef_ok;
  int                 cur_terms = 1;  // reset value of the register
  logic               calm = 1'b0;    // no idling on either side while set
  int                 work_count = 0;
  int                 sample_count = 0;
  int                 spare_count = 0;
  int                 settings_count = 0;
  int                 results_seen = 0;
  int                 stall_cycles = 0;

  always #4 clk = ~clk;

  glm_residual_sum_of_squares_top dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .opcode(opcode), .row_index(row_index),
    .col_index(col_index), .value(value), .last(last),
    .empty(empty), .pop(pop), .residual_ss(residual_ss), .saturated(saturated),
    .terms_in_use_we(terms_in_use_we), .terms_in_use_wdata(terms_in_use_wdata)
  );

  glm_rss_checker checker_i (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .opcode(opcode), .row_index(row_index),
    .col_index(col_index), .value(value), .last(last),
    .empty(empty), .pop(pop), .residual_ss(residual_ss), .saturated(saturated),
    .terms_in_use_we(terms_in_use_we), .terms_in_use_wdata(terms_in_use_wdata),
    .fail_count(fail_count), .expected_left(expected_left)
  );

  // result side: take results at random, about 82 percent of the time, always when calm
  always @(posedge clk) begin
    if (rst) pop <= 1'b0;
    else     pop <= calm || ($urandom_range(0, 99) >= 18);
    if (pop && !empty) results_seen <= results_seen + 1;
  end

  // watchdog: any accepted request or result resets the count
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) stall_cycles <= 0;
    else                                            stall_cycles <= stall_cycles + 1;
    if (stall_cycles == STALL_LIMIT) begin
      $display("watchdog: no traffic for %0d cycles, %0d results outstanding",
               STALL_LIMIT, expected_left);
      $display("Verification failed");
      $finish;
    end
  end

  // Q16.16 values: mostly small and medium magnitudes so that residuals stay
  // in range, with full-range words and the extremes mixed in
  function automatic logic [VAL_W-1:0] rand_q();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2:       return 32'h0000_0000;
          3:       return 32'hFFFF_FFFF;
          default: return 32'h0001_0000;
        endcase
      end
      1, 2, 3, 4: return {{12{r[19]}}, r[19:0]};
      5, 6:       return {{8{r[23]}}, r[23:0]};
      default:    return r;
    endcase
  endfunction

  // One request through the push/full handshake. Gaps are inserted before it;
  // push is only lowered by a gap, so back-to-back requests keep it high.
  task automatic send_req(input logic [1:0] op, input logic [ROW_W-1:0] row,
                          input logic [TERM_W-1:0] col, input logic [VAL_W-1:0] val,
                          input logic lst);
    while (!calm && $urandom_range(0, 99) < 18) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push      <= 1'b1;
    opcode    <= op;
    row_index <= row;
    col_index <= col;
    value     <= val;
    last      <= lst;
    @(posedge clk);
    while (full) @(posedge clk);
    case (op)
      OP_DESIGN: design_ok[row][col] = 1'b1;
      OP_COEF:   coef_ok[col] = 1'b1;
      OP_SAMPLE: sample_count++;
      default:   spare_count++;
    endcase
    if (op != OP_NONE) work_count++;
  endtask

  // a data sample, preceded by loads of any term it would read unloaded
  task automatic send_sample(input logic [ROW_W-1:0] row, input logic [VAL_W-1:0] val,
                             input logic lst);
    int n;
    n = (cur_terms > MAX_TERMS) ? MAX_TERMS : cur_terms;
    for (int k = 0; k < n; k++) begin
      if (!coef_ok[k])
        send_req(OP_COEF, ROW_W'($urandom), TERM_W'(k), rand_q(), 1'(($urandom_range(0, 1))));
      if (!design_ok[row][k])
        send_req(OP_DESIGN, row, TERM_W'(k), rand_q(), 1'($urandom_range(0, 1)));
    end
    send_req(OP_SAMPLE, row, TERM_W'($urandom), val, lst);
  endtask

  // Register write only with the block idle: hold the sender, wait for every
  // outstanding result, then let a sample without last finish in the back end.
  task automatic set_terms(input logic [TERMS_W-1:0] v);
    push <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    terms_in_use_we    <= 1'b1;
    terms_in_use_wdata <= v;
    @(posedge clk);
    terms_in_use_we <= 1'b0;
    cur_terms = int'(v);
    settings_count++;
  endtask

  // One voxel: usually fresh coefficients, then a run of samples ending in
  // last. Some voxels drop last and run on into the next; a little noise
  // (spare opcode, stray loads) is mixed between samples.
  task automatic run_voxel();
    int               n;
    int               cnt;
    logic [ROW_W-1:0] row;
    n = (cur_terms > MAX_TERMS) ? MAX_TERMS : cur_terms;
    if ($urandom_range(0, 9) < 7)
      for (int k = 0; k < n; k++)
        send_req(OP_COEF, ROW_W'($urandom), TERM_W'(k), rand_q(),
                 1'($urandom_range(0, 3) == 0));
    cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 5);
    for (int i = 0; i < cnt; i++) begin
      if ($urandom_range(0, 99) < 8) begin
        case ($urandom_range(0, 2))
          0: send_req(OP_NONE, ROW_W'($urandom), TERM_W'($urandom), $urandom,
                      1'($urandom_range(0, 1)));
          1: send_req(OP_DESIGN, ROW_W'($urandom), TERM_W'($urandom), rand_q(),
                      1'($urandom_range(0, 1)));
          default: send_req(OP_COEF, ROW_W'($urandom), TERM_W'($urandom), rand_q(),
                            1'($urandom_range(0, 1)));
        endcase
      end
      // a small pool of rows fills quickly; the rest spreads over the table
      row = ($urandom_range(0, 9) < 7) ? ROW_W'($urandom_range(0, 23))
                                       : ROW_W'($urandom_range(0, MAX_SAMPLES - 1));
      send_sample(row, rand_q(), (i == cnt - 1) && ($urandom_range(0, 19) != 0));
    end
  endtask

  initial begin
    int start;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed part, register still at its reset value of one term ---
    // last on a load is ignored
    send_req(OP_COEF, 8'd0, 4'd0, 32'h8000_0000, 1'b1);
    send_req(OP_DESIGN, 8'd0, 4'd0, 32'h8000_0000, 1'b0);
    send_req(OP_DESIGN, 8'hFF, 4'hF, 32'h7FFF_FFFF, 1'b1);
    // spare opcode with every field at its top
    send_req(OP_NONE, 8'hFF, 4'hF, 32'hFFFF_FFFF, 1'b1);
    // prediction 2^62 against a full-scale sample: square clamps, then the sum
    send_sample(8'd0, 32'h7FFF_FFFF, 1'b0);
    send_sample(8'd0, 32'h0000_0000, 1'b1);
    // clean voxels: residual of 1.0, then of one LSB
    send_req(OP_COEF, 8'd0, 4'd0, 32'h0001_0000, 1'b0);
    send_req(OP_DESIGN, 8'd1, 4'd0, 32'h0002_0000, 1'b0);
    send_sample(8'd1, 32'h0003_0000, 1'b1);
    send_sample(8'd1, 32'h0002_0001, 1'b1);

    // two terms of 2^62 each: the prediction sum clamps, then the residual
    set_terms(TERMS_W'(2));
    send_req(OP_COEF, 8'd0, 4'd0, 32'h8000_0000, 1'b0);
    send_req(OP_COEF, 8'd0, 4'd1, 32'h8000_0000, 1'b0);
    send_req(OP_DESIGN, 8'd0, 4'd1, 32'h8000_0000, 1'b0);
    send_sample(8'd0, 32'hFFFF_FFFF, 1'b1);

    // no terms: prediction is zero; four squares of 2^62 overflow the sum
    set_terms(TERMS_W'(0));
    send_sample(8'd200, 32'h7FFF_FFFF, 1'b1);
    repeat (3) send_sample(8'd200, 32'h8000_0000, 1'b0);
    send_sample(8'd200, 32'h8000_0000, 1'b1);

    // --- random part, one phase per term setting ---
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_terms(PHASE_TERMS[p*TERMS_W +: TERMS_W]);
      calm <= (p == CALM_PHASE);
      start = work_count;
      while (work_count - start < PER_PHASE) run_voxel();
    end

    push <= 1'b0;
    calm <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("Run covered %0d loads and samples (%0d samples, %0d spare-opcode requests)",
             work_count, sample_count, spare_count);
    $display("and %0d voxel results across %0d term-count settings",
             results_seen, settings_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/glm_rss_pkg.sv
rtl/glm_rss_ram.sv
rtl/glm_rss_front.sv
rtl/glm_rss_cmd_q.sv
rtl/glm_rss_back.sv
rtl/glm_residual_sum_of_squares_top.sv
rtl/glm_rss_checker.sv
tb/sv/glm_rss_checker.sv
tb/sv/tb_glm_residual_sum_of_squares_top.sv
